/* sv/chip_select_bus_interface_core_defines.svh */
// Assertion macros shared by the RTL.
// Both macros expect clk in the scope where they are used; CSBI_ASSERT also expects rst_n.
`ifndef CHIP_SELECT_BUS_INTERFACE_CORE_DEFINES_SVH
`define CHIP_SELECT_BUS_INTERFACE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define CSBI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("csbi assertion failed");
`define CSBI_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("csbi assertion failed");
`else
`define CSBI_ASSERT(lbl, prop)
`define CSBI_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* sv/csbi_pkg.sv */
package csbi_pkg;

  localparam int ADDR_W = 24;

  typedef enum logic [3:0] {
    TGT_IO   = 4'd0,
    TGT_ROM  = 4'd1,
    TGT_CRAM = 4'd2,
    TGT_ARAM = 4'd3,
    TGT_VRAM = 4'd4,
    TGT_CS0  = 4'd5,
    TGT_CS1  = 4'd6,
    TGT_CS2  = 4'd7,
    TGT_CS3  = 4'd8,
    TGT_EXT  = 4'd9
  } csbi_target_t;

  typedef enum logic [2:0] {
    REG_CS0   = 3'd0,
    REG_CS1   = 3'd1,
    REG_CS2   = 3'd2,
    REG_CS3   = 3'd3,
    REG_EXT   = 3'd4,
    REG_FIXED = 3'd5
  } csbi_reg_t;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_WORD = 2'd1,
    SIZE_LONG = 2'd2,
    SIZE_ODD  = 2'd3
  } csbi_size_t;

  localparam logic [ADDR_W-1:0] IO_LAST    = 24'h0000ff;
  localparam logic [ADDR_W-1:0] ROM_FIRST  = 24'hff0000;
  localparam logic [ADDR_W-1:0] CRAM_FIRST = 24'h004000;
  localparam logic [ADDR_W-1:0] CRAM_LAST  = 24'h006fff;
  localparam logic [ADDR_W-1:0] ARAM_FIRST = 24'h007000;
  localparam logic [ADDR_W-1:0] ARAM_LAST  = 24'h007fff;
  localparam logic [ADDR_W-1:0] VRAM_FIRST = 24'h008000;
  localparam logic [ADDR_W-1:0] VRAM_LAST  = 24'h00bfff;
  localparam logic [ADDR_W-1:0] CS2_FIRST  = 24'h000100;

  localparam int CFG_DATA_W = 53;
  localparam int CS_SETUP_W = 52;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic                    kind;
    logic [1:0]              access_size;
    logic [ADDR_W-1:0]       start_address;
    logic [31:0]             write_value;
  } csbi_in_t;

  typedef struct packed {
    logic [3:0]              target;
    logic                    is_write;
    logic [ADDR_W-1:0]       cycle_address;
    logic [1:0]              byte_offset;
    logic [1:0]              byte_count;
    logic [15:0]             cycle_data;
    logic [2:0]              wait_clocks;
    logic                    last;
  } csbi_out_t;

  typedef struct packed {
    logic [3:0][CS_SETUP_W-1:0] cs;
    logic                       cs2_mode;
    logic [2:0]                 ext;
    logic [14:0]                fixed;
  } csbi_cfg_t;

  // One classified access waiting for the bus sequencer
  typedef struct packed {
    csbi_target_t            target;
    logic                    is_write;
    logic [ADDR_W-1:0]       addr;
    csbi_size_t              size;
    logic                    wide;
    logic [2:0]              waits;
    logic [31:0]             data;
  } csbi_desc_t;

  function automatic logic [2:0] wait_of(input logic [1:0] timing);
    logic [2:0] w;
    case (timing)
      2'd0:    w = 3'd4;
      2'd1:    w = 3'd6;
      2'd2:    w = 3'd4;
      default: w = 3'd2;
    endcase
    return w;
  endfunction

endpackage

/* sv/csbi_front.sv */
module csbi_front (
  input  csbi_pkg::csbi_in_t   in_data,
  input  csbi_pkg::csbi_cfg_t  cfg,
  output csbi_pkg::csbi_desc_t desc
);
  import csbi_pkg::*;

  logic [ADDR_W-1:0] addr;
  logic [3:0]        cs_hit;
  logic [2:0]        grp;
  csbi_target_t      tgt;

  assign addr = in_data.start_address;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cs_hit[i] = cfg.cs[i][48] &&
                  (((addr ^ cfg.cs[i][23:0]) & ~cfg.cs[i][47:24]) == '0);
    end
    // Fixed-range mode: everything from the end of the I/O page upward
    if (!cfg.cs2_mode) begin
      cs_hit[2] = cfg.cs[2][48] && (addr >= CS2_FIRST);
    end
  end

  always_comb begin
    if (addr <= IO_LAST) begin
      tgt = TGT_IO;
      grp = cfg.fixed[2:0];
    end else if (addr >= ROM_FIRST) begin
      tgt = TGT_ROM;
      grp = cfg.fixed[5:3];
    end else if (addr >= CRAM_FIRST && addr <= CRAM_LAST) begin
      tgt = TGT_CRAM;
      grp = cfg.fixed[8:6];
    end else if (addr >= ARAM_FIRST && addr <= ARAM_LAST) begin
      tgt = TGT_ARAM;
      grp = cfg.fixed[11:9];
    end else if (addr >= VRAM_FIRST && addr <= VRAM_LAST) begin
      tgt = TGT_VRAM;
      grp = cfg.fixed[14:12];
    end else if (cs_hit[0]) begin
      tgt = TGT_CS0;
      grp = cfg.cs[0][51:49];
    end else if (cs_hit[1]) begin
      tgt = TGT_CS1;
      grp = cfg.cs[1][51:49];
    end else if (cs_hit[2]) begin
      tgt = TGT_CS2;
      grp = cfg.cs[2][51:49];
    end else if (cs_hit[3]) begin
      tgt = TGT_CS3;
      grp = cfg.cs[3][51:49];
    end else begin
      tgt = TGT_EXT;
      grp = cfg.ext;
    end
  end

  always_comb begin
    desc.target   = tgt;
    desc.is_write = in_data.kind;
    desc.addr     = addr;
    desc.size     = (in_data.access_size == SIZE_ODD) ? SIZE_LONG
                                                      : csbi_size_t'(in_data.access_size);
    desc.wide     = grp[0];
    desc.waits    = wait_of(grp[2:1]);
    desc.data     = in_data.write_value;
  end

endmodule

/* sv/csbi_fifo.sv */
module csbi_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  csbi_pkg::csbi_desc_t push_data,
  input  logic                 pop,
  output csbi_pkg::csbi_desc_t pop_data,
  output logic                 full,
  output logic                 empty
);
  import csbi_pkg::*;

  csbi_desc_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (count_r == QCNT_W'(QDEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? bump(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* sv/csbi_back.sv */
module csbi_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  csbi_pkg::csbi_desc_t q_data,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 out_strobe,
  output csbi_pkg::csbi_out_t  out_result
);
  import csbi_pkg::*;

  csbi_desc_t cur_r, cur_nxt;
  logic [1:0] off_r, off_nxt;
  logic       active_r, active_nxt;

  logic [2:0] total;
  logic [2:0] remain;
  logic [2:0] end_off;
  logic [1:0] cnt;
  logic       is_last;
  logic       load;
  logic [7:0] byte_lo, byte_hi;

  always_comb begin
    case (cur_r.size)
      SIZE_BYTE: total = 3'd1;
      SIZE_WORD: total = 3'd2;
      default:   total = 3'd4;
    endcase
    remain  = total - {1'b0, off_r};
    // Two bytes go together only on a 16-bit region at an even address
    cnt     = (cur_r.wide && cur_r.size != SIZE_BYTE && !(cur_r.addr[0] ^ off_r[0]) &&
               remain >= 3'd2) ? 2'd2 : 2'd1;
    end_off = {1'b0, off_r} + {1'b0, cnt};
    is_last = (end_off == total);
    load    = !q_empty && (!active_r || is_last);
  end

  always_comb begin
    byte_lo = cur_r.data[{off_r, 3'b000} +: 8];
    byte_hi = cur_r.data[{off_r + 2'd1, 3'b000} +: 8];
  end

  always_comb begin
    q_pop      = load;
    cur_nxt    = load ? q_data : cur_r;
    active_nxt = active_r;
    off_nxt    = off_r;
    if (load) begin
      active_nxt = 1'b1;
      off_nxt    = '0;
    end else if (active_r) begin
      active_nxt = !is_last;
      off_nxt    = end_off[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      off_r    <= '0;
    end else begin
      active_r <= active_nxt;
      off_r    <= off_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_comb begin
    out_strobe               = active_r;
    out_result.target        = cur_r.target;
    out_result.is_write      = cur_r.is_write;
    out_result.cycle_address = cur_r.addr + {{(ADDR_W-2){1'b0}}, off_r};
    out_result.byte_offset   = off_r;
    out_result.byte_count    = cnt;
    out_result.cycle_data    = '0;
    if (cur_r.is_write) begin
      out_result.cycle_data = {(cnt == 2'd2) ? byte_hi : 8'h00, byte_lo};
    end
    out_result.wait_clocks   = cur_r.waits;
    out_result.last          = is_last;
  end

endmodule

/* sv/chip_select_bus_interface_core.sv */
// Channel  | Handshake              | Payload                 | Direction
// ---------+------------------------+-------------------------+----------
// input    | start / busy           | in_data  (csbi_in_t)    | in
// result   | out_strobe, one cycle  | out_result (csbi_out_t) | out
// config   | cfg_valid / cfg_ready  | cfg_index, cfg_data     | in
//
// An access splits into one to four bus cycles, one clock for every bus cycle;
// the bus sequencer in the back end sets that rate.
// First bus cycle is taken once the start beat has passed the queue, then the sequencer.
// Reset (rst_n low, synchronous) empties the queue, idles the sequencer and
// clears every setup register to zero.
// busy rises only while the two-entry access queue is full; the receiver of
// result beats cannot stall, so the sequencer never waits on it.
module chip_select_bus_interface_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  csbi_pkg::csbi_in_t  in_data,
  output logic                out_strobe,
  output csbi_pkg::csbi_out_t out_result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [csbi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import csbi_pkg::*;
  `include "chip_select_bus_interface_core_defines.svh"

  // Setup registers
  logic [3:0][CS_SETUP_W-1:0] cs_r, cs_nxt;
  logic                       cs2_mode_r, cs2_mode_nxt;
  logic [2:0]                 ext_r, ext_nxt;
  logic [14:0]                fixed_r, fixed_nxt;
  csbi_cfg_t                  cfg;

  csbi_desc_t front_desc;
  csbi_desc_t q_data;
  logic       q_full, q_empty, q_pop;
  logic       push;

  assign cfg_ready = 1'b1;

  // Decode the register index and latch the setup beat
  always_comb begin
    cs_nxt       = cs_r;
    cs2_mode_nxt = cs2_mode_r;
    ext_nxt      = ext_r;
    fixed_nxt    = fixed_r;
    if (cfg_valid && cfg_ready) begin
      case (csbi_reg_t'(cfg_index))
        REG_CS0:   cs_nxt[0] = cfg_data[CS_SETUP_W-1:0];
        REG_CS1:   cs_nxt[1] = cfg_data[CS_SETUP_W-1:0];
        REG_CS2: begin
          cs_nxt[2]    = cfg_data[CS_SETUP_W-1:0];
          cs2_mode_nxt = cfg_data[CS_SETUP_W];
        end
        REG_CS3:   cs_nxt[3] = cfg_data[CS_SETUP_W-1:0];
        REG_EXT:   ext_nxt   = cfg_data[2:0];
        REG_FIXED: fixed_nxt = cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r       <= '0;
      cs2_mode_r <= 1'b0;
      ext_r      <= '0;
      fixed_r    <= '0;
    end else begin
      cs_r       <= cs_nxt;
      cs2_mode_r <= cs2_mode_nxt;
      ext_r      <= ext_nxt;
      fixed_r    <= fixed_nxt;
    end
  end

  always_comb begin
    cfg.cs       = cs_r;
    cfg.cs2_mode = cs2_mode_r;
    cfg.ext      = ext_r;
    cfg.fixed    = fixed_r;
  end

  // Front end: classify the access in the cycle of its start beat
  assign busy = q_full;
  assign push = start && !busy;

  csbi_front u_front (
    .in_data (in_data),
    .cfg     (cfg),
    .desc    (front_desc)
  );

  // Decouple the classifier from the bus sequencer
  csbi_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_desc),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back end: emit one bus cycle per clock
  csbi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_data     (q_data),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_result (out_result)
  );

  // A bus cycle that is not the last is always followed by the next one
  `CSBI_ASSERT(a_cycle_follows, (out_strobe && !out_result.last) |=> out_strobe)
  // Consecutive cycles of one access advance the offset by the bytes moved
  `CSBI_ASSERT(a_offset_advance, (out_strobe && !out_result.last) |=> (out_result.byte_offset == $past(out_result.byte_offset + out_result.byte_count)))
  // Hold the decoded target across all cycles of one access
  `CSBI_ASSERT(a_target_held, (out_strobe && !out_result.last) |=> (out_result.target == $past(out_result.target)))
  // Drop the strobe after the final cycle when nothing is queued
  `CSBI_ASSERT(a_idle_after_last, (out_strobe && out_result.last && q_empty && !push) |=> !out_strobe)
  // No strobe straight out of reset
  `CSBI_ASSERT_ALWAYS(a_quiet_reset, !rst_n |=> !out_strobe)

endmodule
